>>> hw/rtl/ksdlp_pkg.sv
package ksdlp_pkg;

    localparam int NUM_KEYS   = 4;
    localparam int CODE_W     = 8;
    localparam int COUNT_W    = 16;
    localparam int ACTIVE_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODE_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODE_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODE_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODE_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_KEYS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT       = 3'd6;

    localparam logic [COUNT_W-1:0] LONG_PRESS_RESET = 16'd100;
    localparam logic [COUNT_W-1:0] REPEAT_RESET     = 16'd20;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_CONFIRM = 4'b0010,
        PH_PRESSED = 4'b0100,
        PH_LONG    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0][CODE_W-1:0] key_code;
        logic [ACTIVE_W-1:0]             active_keys;
        logic [COUNT_W-1:0]              long_press_ticks;
        logic [COUNT_W-1:0]              repeat_ticks;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              is_long;
    } key_event_t;

endpackage

>>> hw/rtl/ksdlp_cfg_regs.sv
module ksdlp_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ksdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ksdlp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ksdlp_pkg::cfg_t                    cfg
);
    import ksdlp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_CODE_0:  cfg_next.key_code[0] = cfg_data[CODE_W-1:0];
                CFG_KEY_CODE_1:  cfg_next.key_code[1] = cfg_data[CODE_W-1:0];
                CFG_KEY_CODE_2:  cfg_next.key_code[2] = cfg_data[CODE_W-1:0];
                CFG_KEY_CODE_3:  cfg_next.key_code[3] = cfg_data[CODE_W-1:0];
                CFG_ACTIVE_KEYS: cfg_next.active_keys = cfg_data[ACTIVE_W-1:0];
                CFG_LONG_PRESS:  cfg_next.long_press_ticks = cfg_data[COUNT_W-1:0];
                CFG_REPEAT:      cfg_next.repeat_ticks = cfg_data[COUNT_W-1:0];
                default:         cfg_next = cfg_reg;   // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_code         <= '0;
            cfg_reg.active_keys      <= '0;
            cfg_reg.long_press_ticks <= LONG_PRESS_RESET;
            cfg_reg.repeat_ticks     <= REPEAT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/ksdlp_code_sel.sv
module ksdlp_code_sel (
    input  ksdlp_pkg::cfg_t                    cfg,
    input  logic [ksdlp_pkg::NUM_KEYS-1:0]     levels,
    output logic [ksdlp_pkg::CODE_W-1:0]       code
);
    import ksdlp_pkg::*;

    localparam logic [ACTIVE_W-1:0] MAX_ACTIVE = ACTIVE_W'(NUM_KEYS);

    logic [ACTIVE_W-1:0] n_keys;

    // clamp active count, then highest enabled pressed key with nonzero code wins
    always_comb
    begin
        n_keys = (cfg.active_keys > MAX_ACTIVE) ? MAX_ACTIVE : cfg.active_keys;
        code   = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if ((ACTIVE_W'(i) < n_keys) && levels[i] && (cfg.key_code[i] != '0))
            begin
                code = cfg.key_code[i];
            end
        end
    end

endmodule

>>> hw/rtl/ksdlp_fsm.sv
module ksdlp_fsm (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step,
    input  logic [ksdlp_pkg::CODE_W-1:0]       code,
    input  ksdlp_pkg::cfg_t                    cfg,
    output ksdlp_pkg::key_event_t              evt
);
    import ksdlp_pkg::*;

    phase_t             phase_reg,      phase_next;
    logic [CODE_W-1:0]  held_code_reg,  held_code_next;
    logic [COUNT_W-1:0] hold_count_reg, hold_count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               same;
    key_event_t         evt_raw;

    assign count_inc = hold_count_reg + COUNT_W'(1);   // wraps
    assign same      = (code == held_code_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        held_code_next  = held_code_reg;
        hold_count_next = hold_count_reg;
        evt_raw         = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (code != '0)
                begin
                    held_code_next = code;
                    phase_next     = PH_CONFIRM;
                end
            end
            PH_CONFIRM:
            begin
                if (same)
                begin
                    hold_count_next = '0;
                    phase_next      = PH_PRESSED;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_PRESSED:
            begin
                if (same)
                begin
                    hold_count_next = count_inc;
                    if (count_inc > cfg.long_press_ticks)
                    begin
                        hold_count_next = '0;
                        phase_next      = PH_LONG;
                        evt_raw.code    = held_code_reg;
                        evt_raw.is_long = 1'b1;
                    end
                end
                else
                begin
                    // release before threshold: short press
                    phase_next   = PH_IDLE;
                    evt_raw.code = held_code_reg;
                end
            end
            PH_LONG:
            begin
                if (same)
                begin
                    hold_count_next = count_inc;
                    if (count_inc > cfg.repeat_ticks)
                    begin
                        hold_count_next = '0;
                        evt_raw.code    = held_code_reg;
                        evt_raw.is_long = 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;   // silent release
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        evt.code    = evt_raw.code;
        evt.is_long = evt_raw.is_long && (evt_raw.code != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_code_reg  <= '0;
            hold_count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            held_code_reg  <= held_code_next;
            hold_count_reg <= hold_count_next;
        end
    end

endmodule

>>> hw/rtl/key_scan_debounce_long_press.sv
// Path: an accepted tick is held in the input register, then its event moves to the result
// register once the result slot is free, and is transferred on m_tdata/m_tuser from there.
// Throughput: one tick per cycle while m_tready keeps the result slot free; the key-code
// select and phase update sit in one stage between the input register and result register.
// Reset (rst_n, async, active low): phase idle, held code and hold count zero,
// key codes zero, active_keys zero, long threshold 100, repeat interval 20.
module key_scan_debounce_long_press (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_we,
    input  logic [ksdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ksdlp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // tick input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [3:0] key_levels, [7:4] zero
    // event output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] event_code
    output logic                               m_tuser    // [0] is_long
);
    import ksdlp_pkg::*;

    // Input stage: holds one scan tick.
    logic                in_valid_reg, in_valid_next;
    logic [NUM_KEYS-1:0] levels_reg;

    // Result stage: holds one event until the downstream transfer.
    logic                out_valid_reg, out_valid_next;
    key_event_t          out_evt_reg;

    cfg_t                cfg;
    logic [CODE_W-1:0]   tick_code;
    key_event_t          evt;
    logic                out_free;
    logic                step;
    logic                in_xfer;

    // Result slot is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_tready;
    // Tick moves from input stage to result stage: state machine steps.
    assign step     = in_valid_reg && out_free;
    // Input stage takes a new tick when empty or emptying this cycle.
    assign s_tready = !in_valid_reg || out_free;
    assign in_xfer  = s_tvalid && s_tready;

    ksdlp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ksdlp_code_sel u_code_sel (
        .cfg    (cfg),
        .levels (levels_reg),
        .code   (tick_code)
    );

    ksdlp_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .code  (tick_code),
        .cfg   (cfg),
        .evt   (evt)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            levels_reg <= s_tdata[NUM_KEYS-1:0];
        end
        if (step)
        begin
            out_evt_reg <= evt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_evt_reg.code;
    assign m_tuser  = out_evt_reg.is_long;

`ifndef SYNTH
    // long flag never accompanies an empty event
    a_long_has_code : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata != '0)
        else $error("is_long set with zero event code");

    // every stepped tick lands in the result stage
    a_step_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("stepped tick did not reach result stage");

    // an accepted tick is held in the input stage
    a_in_captured : assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_valid_reg)
        else $error("accepted tick lost from input stage");
`endif

endmodule
